>>> hdl/kfci_pkg.sv
// Shared types and constants of the keyframe curve interpolator.
package kfci_pkg;

   // Command codes of an input item
   typedef enum logic [2:0] {
      CMD_ADD         = 3'd0,
      CMD_REMOVE      = 3'd1,
      CMD_MOVE        = 3'd2,
      CMD_EVAL_LINEAR = 3'd3,
      CMD_EVAL_STEP   = 3'd4
   } cmd_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_MERGE_TOL   = 2'd0,
      CSR_WRAP_BEFORE = 2'd1,
      CSR_WRAP_AFTER  = 2'd2
   } csr_index_type;

   // Wrap modes; any other code behaves as clamp
   localparam logic [1:0] WRAP_REPEAT   = 2'd1;
   localparam logic [1:0] WRAP_PINGPONG = 2'd2;

   localparam logic [30:0] MERGE_TOL_RESET = 31'd66;

   // Shared arithmetic unit operations
   typedef enum logic {
      ALU_DIV = 1'b0,
      ALU_MUL = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   // One stored key
   typedef struct packed {
      logic signed [31:0] ktime;
      logic signed [31:0] kvalue;
   } key_type;

   localparam int KEY_W = 64;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] key_time;
      logic signed [31:0] target_time;
      logic signed [31:0] key_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
      logic [5:0]         key_count;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_START,
      S_FIND,
      S_RM_GO,
      S_RM,
      S_A_FIRST,
      S_A_LAST,
      S_A_SCAN,
      S_INS,
      S_INS_WR,
      S_E_FIRST,
      S_E_LAST,
      S_E_WDIV,
      S_E_SCAN,
      S_E_PICK,
      S_E_LDIV,
      S_E_MUL,
      S_DONE
   } state_type;

endpackage

>>> hdl/kfci_ram.sv
// Generic single write port, single read port RAM with registered read.
module kfci_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/kfci_alu.sv
// Shared iterative unit: restoring divider and shift-add multiplier, one bit a cycle.
module kfci_alu
   import kfci_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  alu_ctl_type        ctl,
   input  logic [63:0]        opa,
   input  logic [32:0]        opb,
   output logic [63:0]        quot,
   output logic [32:0]        rem,
   output logic signed [65:0] prod,
   output logic               done
);

   localparam logic [5:0] DIV_LAST = 6'd63;
   localparam logic [5:0] MUL_LAST = 6'd31;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   alu_op_type         op_ff, op_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [63:0]        quot_ff, quot_in;
   logic [32:0]        rem_ff, rem_in;
   logic [32:0]        dvs_ff, dvs_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [65:0] mc_ff, mc_in;
   logic [31:0]        mp_ff, mp_in;
   logic [33:0]        shifted;
   logic               last_step;

   assign shifted   = {rem_ff, quot_ff[63]};
   assign last_step = (op_ff == ALU_DIV) ? (cnt_ff == DIV_LAST) : (cnt_ff == MUL_LAST);

   // Load operands or advance one step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      acc_in  = acc_ff;
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = '0;
         quot_in = opa;
         rem_in  = '0;
         dvs_in  = opb;
         acc_in  = '0;
         mc_in   = {{33{opb[32]}}, opb};
         mp_in   = opa[31:0];
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_DIV: begin
               if (shifted >= {1'b0, dvs_ff}) begin
                  rem_in  = 33'(shifted - {1'b0, dvs_ff});
                  quot_in = {quot_ff[62:0], 1'b1};
               end else begin
                  rem_in  = shifted[32:0];
                  quot_in = {quot_ff[62:0], 1'b0};
               end
            end
            ALU_MUL: begin
               if (mp_ff[0]) begin
                  acc_in = acc_ff + mc_ff;
               end
               mc_in = mc_ff <<< 1;
               mp_in = mp_ff >> 1;
            end
         endcase
         cnt_in = cnt_ff + 6'd1;
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      acc_ff  <= acc_in;
      mc_ff   <= mc_in;
      mp_ff   <= mp_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;
   assign prod = acc_ff;
   assign done = done_ff;

endmodule

>>> hdl/keyframe_curve_interpolator_top.sv
// Top level of the keyframe curve interpolator: sequencer, key table and shared unit.
// One item at a time; the next item is taken once the sequencer is back in idle.
// The key table is one RAM port pair, one entry read and one written per cycle.
// Synchronous reset empties the table (count only) and restores state, output valid and configuration.
module keyframe_curve_interpolator_top
   import kfci_pkg::*;
#(
   parameter int MAX_KEYS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int IW = $clog2(MAX_KEYS);
   localparam int CW = $clog2(MAX_KEYS + 1);

   function automatic logic signed [32:0] sx(input logic [31:0] a);
      return {a[31], a};
   endfunction

   function automatic logic near(input logic [31:0] a, input logic [31:0] b,
                                 input logic [30:0] tol);
      logic signed [32:0] d;
      logic [32:0]        m;
      d = sx(a) - sx(b);
      m = d[32] ? 33'(-d) : d;
      return m <= {2'b00, tol};
   endfunction

   state_type          state_ff, state_in;
   logic [2:0]         cmd_ff, cmd_in;
   logic [31:0]        t_ff, t_in;
   logic [31:0]        tgt_ff, tgt_in;
   logic [31:0]        v_ff, v_in;
   logic [31:0]        first_ff, first_in;
   key_type            prev_ff, prev_in;
   key_type            k0_ff, k0_in;
   key_type            k1_ff, k1_in;
   logic [IW-1:0]      ptr_ff, ptr_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               phase_ff, phase_in;
   logic [31:0]        result_ff, result_in;
   status_type         status_ff, status_in;
   logic [30:0]        tol_ff, tol_in;
   logic [1:0]         wb_ff, wb_in;
   logic [1:0]         wa_ff, wa_in;
   logic [32:0]        span_ff, span_in;
   logic               dneg_ff, dneg_in;
   logic               pp_ff, pp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_item_ff, rsp_item_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   key_type            wr_data;
   logic [IW-1:0]      rd_addr;
   logic [KEY_W-1:0]   rd_raw;
   key_type            rd_q;

   alu_ctl_type        alu_ctl;
   logic [63:0]        alu_a;
   logic [32:0]        alu_b;
   logic [63:0]        alu_quot;
   logic [32:0]        alu_rem;
   logic signed [65:0] alu_prod;
   logic               alu_done;

   logic               ins_req;
   logic [CW-1:0]      ins_pos;
   logic [IW-1:0]      last_idx;
   logic               full;
   logic [31:0]        search_t;
   logic signed [32:0] e_span;
   logic signed [32:0] e_d;
   logic [32:0]        e_dmag;
   logic [1:0]         e_mode;
   logic               e_before;
   logic               e_after;
   logic               w_neg_rem;
   logic [32:0]        w_r;
   logic               w_qodd;
   logic [32:0]        w_t;
   logic signed [65:0] rnd;
   logic signed [65:0] rnd_sh;
   logic signed [32:0] l_tdiff;

   kfci_ram #(
      .WIDTH(KEY_W),
      .DEPTH(MAX_KEYS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   kfci_alu u_alu (
      .clock(clock),
      .reset(reset),
      .ctl  (alu_ctl),
      .opa  (alu_a),
      .opb  (alu_b),
      .quot (alu_quot),
      .rem  (alu_rem),
      .prod (alu_prod),
      .done (alu_done)
   );

   assign rd_q     = rd_raw;
   assign last_idx = IW'(count_ff - CW'(1));
   assign full     = (count_ff == CW'(MAX_KEYS));
   assign search_t = phase_ff ? tgt_ff : t_ff;

   // Wrap arithmetic: rd_q holds the last key while in S_E_LAST
   assign e_span   = sx(rd_q.ktime) - sx(first_ff);
   assign e_d      = sx(t_ff) - sx(first_ff);
   assign e_dmag   = e_d[32] ? 33'(-e_d) : e_d;
   assign e_before = $signed(t_ff) < $signed(first_ff);
   assign e_after  = $signed(t_ff) > $signed(rd_q.ktime);
   assign e_mode   = e_before ? wb_ff : wa_ff;

   // Floored remainder and quotient parity
   assign w_neg_rem = dneg_ff && (alu_rem != '0);
   assign w_r       = w_neg_rem ? 33'(span_ff - alu_rem) : alu_rem;
   assign w_qodd    = w_neg_rem ? ~alu_quot[0] : alu_quot[0];
   assign w_t       = (pp_ff && w_qodd) ? 33'(sx(first_ff) + span_ff - w_r)
                                        : 33'(sx(first_ff) + w_r);

   // Blend rounding: floor((prod + 2^30) / 2^31)
   assign rnd     = alu_prod + 66'sh40000000;
   assign rnd_sh  = rnd >>> 31;
   assign l_tdiff = sx(t_ff) - sx(k0_ff.ktime);

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Sequencer: next state, table access and unit control
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      t_in         = t_ff;
      tgt_in       = tgt_ff;
      v_in         = v_ff;
      first_in     = first_ff;
      prev_in      = prev_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      result_in    = result_ff;
      status_in    = status_ff;
      span_in      = span_ff;
      dneg_in      = dneg_ff;
      pp_in        = pp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      alu_ctl      = '{start: 1'b0, op: ALU_DIV};
      alu_a        = '0;
      alu_b        = '0;
      ins_req      = 1'b0;
      ins_pos      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_item.command;
               t_in      = req_item.key_time;
               tgt_in    = req_item.target_time;
               v_in      = req_item.key_value;
               status_in = ST_OK;
               result_in = '0;
               state_in  = S_START;
            end
         end

         S_START: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = '{ktime: t_ff, kvalue: v_ff};
                     count_in = CW'(1);
                     state_in = S_DONE;
                  end else begin
                     state_in = S_A_FIRST;
                  end
               end
               CMD_REMOVE, CMD_MOVE: begin
                  if (count_ff == '0) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = S_DONE;
                  end else begin
                     phase_in = 1'b0;
                     ptr_in   = '0;
                     state_in = S_FIND;
                  end
               end
               CMD_EVAL_LINEAR, CMD_EVAL_STEP: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_E_FIRST;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // Search for a key near key_time, then (move only) near target_time
         S_FIND: begin
            if (near(rd_q.ktime, search_t, tol_ff)) begin
               if (!phase_ff) begin
                  idx_in = ptr_ff;
                  v_in   = rd_q.kvalue;
                  if (cmd_ff == CMD_MOVE) begin
                     phase_in = 1'b1;
                     ptr_in   = '0;
                  end else begin
                     state_in = S_RM_GO;
                  end
               end else begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end
            end else if (ptr_ff == last_idx) begin
               if (!phase_ff) begin
                  status_in = ST_NOT_FOUND;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_RM_GO;
               end
            end else begin
               rd_addr = ptr_ff + 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end
         end

         // Close the gap left by the removed key
         S_RM_GO: begin
            if (idx_ff == last_idx) begin
               count_in = count_ff - CW'(1);
               if (cmd_ff == CMD_MOVE) begin
                  cmd_in   = CMD_ADD;
                  t_in     = tgt_ff;
                  state_in = S_START;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               rd_addr  = idx_ff + 1'b1;
               ptr_in   = idx_ff + 1'b1;
               state_in = S_RM;
            end
         end

         S_RM: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff - 1'b1;
            wr_data = rd_q;
            if (ptr_ff == last_idx) begin
               count_in = count_ff - CW'(1);
               if (cmd_ff == CMD_MOVE) begin
                  cmd_in   = CMD_ADD;
                  t_in     = tgt_ff;
                  state_in = S_START;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               rd_addr = ptr_ff + 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end
         end

         // Add: fetch both ends first
         S_A_FIRST: begin
            first_in = rd_q.ktime;
            rd_addr  = last_idx;
            state_in = S_A_LAST;
         end

         S_A_LAST: begin
            if ($signed(t_ff) < $signed(first_ff)) begin
               if ($signed(sx(first_ff) - sx(t_ff)) > $signed({2'b00, tol_ff})) begin
                  ins_req = 1'b1;
                  ins_pos = '0;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = '{ktime: first_ff, kvalue: v_ff};
                  state_in = S_DONE;
               end
            end else if ($signed(t_ff) > $signed(rd_q.ktime)) begin
               if ($signed(sx(t_ff) - sx(rd_q.ktime)) > $signed({2'b00, tol_ff})) begin
                  ins_req = 1'b1;
                  ins_pos = count_ff;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = last_idx;
                  wr_data  = '{ktime: rd_q.ktime, kvalue: v_ff};
                  state_in = S_DONE;
               end
            end else begin
               ptr_in   = '0;
               state_in = S_A_SCAN;
            end
         end

         // Add inside the span: merge or insert between neighbors
         S_A_SCAN: begin
            if (ptr_ff != '0 && $signed(t_ff) > $signed(prev_ff.ktime)
                && $signed(t_ff) < $signed(rd_q.ktime)
                && !near(rd_q.ktime, t_ff, tol_ff)) begin
               ins_req = 1'b1;
               ins_pos = CW'(ptr_ff);
            end else if (near(rd_q.ktime, t_ff, tol_ff)) begin
               wr_en    = 1'b1;
               wr_addr  = ptr_ff;
               wr_data  = '{ktime: rd_q.ktime, kvalue: v_ff};
               state_in = S_DONE;
            end else if (ptr_ff == last_idx) begin
               state_in = S_DONE;
            end else begin
               prev_in = rd_q;
               rd_addr = ptr_ff + 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end
         end

         // Shift entries up from the end down to the insert position
         S_INS: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff + 1'b1;
            wr_data = rd_q;
            if (ptr_ff == pos_ff) begin
               state_in = S_INS_WR;
            end else begin
               rd_addr = ptr_ff - 1'b1;
               ptr_in  = ptr_ff - 1'b1;
            end
         end

         S_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = '{ktime: t_ff, kvalue: v_ff};
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end

         // Evaluate: fetch both ends, then wrap
         S_E_FIRST: begin
            first_in = rd_q.ktime;
            rd_addr  = last_idx;
            state_in = S_E_LAST;
         end

         S_E_LAST: begin
            ptr_in   = '0;
            state_in = S_E_SCAN;
            if (e_before || e_after) begin
               if ($signed(e_span) <= $signed({2'b00, tol_ff})
                   || !(e_mode == WRAP_REPEAT || e_mode == WRAP_PINGPONG)) begin
                  t_in = e_before ? first_ff : rd_q.ktime;
               end else begin
                  alu_ctl  = '{start: 1'b1, op: ALU_DIV};
                  alu_a    = {31'b0, e_dmag};
                  alu_b    = e_span;
                  span_in  = e_span;
                  dneg_in  = e_d[32];
                  pp_in    = (e_mode == WRAP_PINGPONG);
                  state_in = S_E_WDIV;
               end
            end
         end

         S_E_WDIV: begin
            if (alu_done) begin
               t_in     = w_t[31:0];
               ptr_in   = '0;
               state_in = S_E_SCAN;
            end
         end

         // Find the first bracketing pair from the front
         S_E_SCAN: begin
            if (ptr_ff == '0) begin
               if (count_ff == CW'(1)) begin
                  k0_in    = rd_q;
                  k1_in    = rd_q;
                  state_in = S_E_PICK;
               end else begin
                  prev_in = rd_q;
                  rd_addr = ptr_ff + 1'b1;
                  ptr_in  = ptr_ff + 1'b1;
               end
            end else if ($signed(prev_ff.ktime) <= $signed(t_ff)
                         && $signed(t_ff) <= $signed(rd_q.ktime)) begin
               k0_in    = prev_ff;
               k1_in    = rd_q;
               state_in = S_E_PICK;
            end else if (ptr_ff == last_idx) begin
               k0_in    = rd_q;
               k1_in    = rd_q;
               state_in = S_E_PICK;
            end else begin
               prev_in = rd_q;
               rd_addr = ptr_ff + 1'b1;
               ptr_in  = ptr_ff + 1'b1;
            end
         end

         S_E_PICK: begin
            if (cmd_ff == CMD_EVAL_STEP) begin
               result_in = (t_ff == k1_ff.ktime) ? k1_ff.kvalue : k0_ff.kvalue;
               state_in  = S_DONE;
            end else if ($signed(k0_ff.ktime) >= $signed(k1_ff.ktime)
                         || $signed(t_ff) < $signed(k0_ff.ktime)
                         || $signed(t_ff) > $signed(k1_ff.ktime)) begin
               result_in = k0_ff.kvalue;
               state_in  = S_DONE;
            end else begin
               alu_ctl  = '{start: 1'b1, op: ALU_DIV};
               alu_a    = {1'b0, l_tdiff[31:0], 31'b0};
               alu_b    = 33'(sx(k1_ff.ktime) - sx(k0_ff.ktime));
               state_in = S_E_LDIV;
            end
         end

         S_E_LDIV: begin
            if (alu_done) begin
               alu_ctl  = '{start: 1'b1, op: ALU_MUL};
               alu_a    = {32'b0, alu_quot[31:0]};
               alu_b    = 33'(sx(k1_ff.kvalue) - sx(k0_ff.kvalue));
               state_in = S_E_MUL;
            end
         end

         S_E_MUL: begin
            if (alu_done) begin
               result_in = k0_ff.kvalue + rnd_sh[31:0];
               state_in  = S_DONE;
            end
         end

         // Hand the item to the output register
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{result_value: result_ff, status: status_ff,
                                key_count: 6'(count_ff)};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Common insert start: refuse when full, append, or shift up
      if (ins_req) begin
         if (full) begin
            status_in = ST_FULL;
            state_in  = S_DONE;
         end else if (ins_pos == count_ff) begin
            wr_en    = 1'b1;
            wr_addr  = IW'(count_ff);
            wr_data  = '{ktime: t_ff, kvalue: v_ff};
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end else begin
            pos_in   = IW'(ins_pos);
            rd_addr  = last_idx;
            ptr_in   = last_idx;
            state_in = S_INS;
         end
      end

      // Reading entry zero starts every scan
      if (state_in == S_FIND && state_ff != S_FIND) begin
         rd_addr = '0;
      end
      if (state_ff == S_FIND && phase_in && !phase_ff) begin
         rd_addr = '0;
      end
      if ((state_in == S_A_FIRST || state_in == S_E_FIRST || state_in == S_A_SCAN
           || state_in == S_E_SCAN) && state_in != state_ff) begin
         rd_addr = '0;
      end
   end

   // Configuration writes
   always_comb begin
      tol_in = tol_ff;
      wb_in  = wb_ff;
      wa_in  = wa_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MERGE_TOL:   tol_in = csr_data[30:0];
            CSR_WRAP_BEFORE: wb_in  = csr_data[1:0];
            CSR_WRAP_AFTER:  wa_in  = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         tol_ff       <= MERGE_TOL_RESET;
         wb_ff        <= '0;
         wa_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tol_ff       <= tol_in;
         wb_ff        <= wb_in;
         wa_ff        <= wa_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      t_ff        <= t_in;
      tgt_ff      <= tgt_in;
      v_ff        <= v_in;
      first_ff    <= first_in;
      prev_ff     <= prev_in;
      k0_ff       <= k0_in;
      k1_ff       <= k1_in;
      ptr_ff      <= ptr_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      phase_ff    <= phase_in;
      result_ff   <= result_in;
      status_ff   <= status_in;
      span_ff     <= span_in;
      dneg_ff     <= dneg_in;
      pp_ff       <= pp_in;
      rsp_item_ff <= rsp_item_in;
   end

endmodule
